/* rtl/core/aifs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ASCII integer field scanner.
// Used by aifs_scan, aifs_format and the top level; depends on nothing.
package aifs_pkg;

    // Longest field accepted when field_width is zero or too large
    localparam int unsigned MAX_FIELD_CHARS = 31;

    // Configuration register map (word index on paddr[4:2])
    localparam int unsigned CFG_ADDR_W = 5;
    localparam logic [2:0] REG_BASE_MODE      = 3'd0;
    localparam logic [2:0] REG_FIELD_WIDTH    = 3'd1;
    localparam logic [2:0] REG_UNSIGNED_MODE  = 3'd2;
    localparam logic [2:0] REG_PREFIX_ALLOWED = 3'd3;
    localparam logic [2:0] REG_SUPPRESS_VALUE = 3'd4;

    // Base codes
    localparam logic [4:0] BASE_AUTO = 5'd0;
    localparam logic [4:0] BASE_OCT  = 5'd8;
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [4:0] base_mode;
        logic [4:0] field_width;
        logic       unsigned_mode;
        logic       prefix_allowed;
        logic       suppress_value;
    } cfg_t;

    // Per-field scan state (phase bit is kept separately)
    typedef struct packed {
        logic        sign_ok;
        logic        no_digits_yet;
        logic        prefix_ok;
        logic        no_nonzero_seen;
        logic [4:0]  working_base;
        logic [7:0]  accepted_count;
        logic [63:0] magnitude;
        logic        is_negative;
        logic        saturated;
        logic        last_was_x;
    } scan_state_t;

    // Finished field handed from the scanner to the formatter
    typedef struct packed {
        logic [63:0] magnitude;
        logic        is_negative;
        logic        saturated;
        logic        no_digits;
        logic [7:0]  chars_used;
        logic [1:0]  unused_tail;
    } field_rec_t;

    // Map an unsupported base code to decimal
    function automatic logic [4:0] legal_base(input logic [4:0] b);
        logic [4:0] r;
        r = BASE_DEC;
        if (b == BASE_AUTO || b == BASE_OCT || b == BASE_HEX) begin
            r = b;
        end
        return r;
    endfunction

endpackage

/* rtl/core/ascii_integer_field_scanner.sv */
`timescale 1ns / 1ps
// Top level of the ASCII integer field scanner: input register, APB
// configuration registers, scanner and formatter. Depends on aifs_pkg.
//
// Usage:
//   Characters enter on the s_ stream, one per request: s_tdata carries the
//   byte, s_tlast marks the last character of the text. Each integer field
//   yields one result on the m_ stream: m_tdata holds the 64-bit value, the
//   characters used and the unused tail; m_tuser holds the failure flag and
//   the overflow flag.
//   Result path: a character that closes a field has its result loaded
//   into the finished-field register, then the output register, which
//   drives m_tvalid. Throughput: one character per cycle while not stalled;
//   each scan state update is one shift-add by 8, 10 or 16 on the magnitude.
//   When the receiver stalls, the output register and the finished-field
//   register both hold; once both are full the scanner stops and s_tready
//   falls as soon as the input register holds a character.
//   Reset (aresetn low, synchronous) empties all stages, returns the
//   scanner to whitespace skipping and loads the register defaults:
//   base 10, field width 0 (31 characters), signed, no prefix, no skip.
//   Write configuration only while no field is in progress.
module ascii_integer_field_scanner (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Character stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] text_char
    input  logic                              s_tlast,   // end_of_text
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [63:0] number, [71:64] chars_used, [73:72] unused_tail, [79:74] zero
    output logic [79:0]                       m_tdata,
    // [0] scan_status, [1] range_overflow
    output logic [1:0]                        m_tuser,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aifs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    aifs_pkg::cfg_t       cfg_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 in_last_reg;
    logic                 step;
    logic                 rec_free;
    logic                 out_free;
    logic                 rec_valid;
    aifs_pkg::field_rec_t rec;
    logic                 cfg_write;
    logic [2:0]           reg_index;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_mode      <= aifs_pkg::BASE_DEC;
            cfg_reg.field_width    <= 5'd0;
            cfg_reg.unsigned_mode  <= 1'b0;
            cfg_reg.prefix_allowed <= 1'b0;
            cfg_reg.suppress_value <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_index)
                aifs_pkg::REG_BASE_MODE:      cfg_reg.base_mode      <= pwdata[4:0];
                aifs_pkg::REG_FIELD_WIDTH:    cfg_reg.field_width    <= pwdata[4:0];
                aifs_pkg::REG_UNSIGNED_MODE:  cfg_reg.unsigned_mode  <= pwdata[0];
                aifs_pkg::REG_PREFIX_ALLOWED: cfg_reg.prefix_allowed <= pwdata[0];
                aifs_pkg::REG_SUPPRESS_VALUE: cfg_reg.suppress_value <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_index)
            aifs_pkg::REG_BASE_MODE:      prdata = {27'd0, cfg_reg.base_mode};
            aifs_pkg::REG_FIELD_WIDTH:    prdata = {27'd0, cfg_reg.field_width};
            aifs_pkg::REG_UNSIGNED_MODE:  prdata = {31'd0, cfg_reg.unsigned_mode};
            aifs_pkg::REG_PREFIX_ALLOWED: prdata = {31'd0, cfg_reg.prefix_allowed};
            aifs_pkg::REG_SUPPRESS_VALUE: prdata = {31'd0, cfg_reg.suppress_value};
            default:                      prdata = 32'd0;
        endcase
    end

    // Pipeline flow: a character advances when the record stage can take a result
    assign rec_free = !rec_valid || out_free;
    assign step     = in_valid_reg && rec_free;
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    aifs_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_char   (in_char_reg),
        .in_last   (in_last_reg),
        .cfg       (cfg_reg),
        .rec_load  (rec_free),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    aifs_format u_format (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec       (rec),
        .cfg       (cfg_reg),
        .m_tready  (m_tready),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/core/aifs_scan.sv */
`timescale 1ns / 1ps
// Character-by-character scan state machine of the integer field scanner,
// plus the register that holds a finished field. Depends on aifs_pkg.
module aifs_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,        // consume the registered character
    input  logic [7:0]          in_char,
    input  logic                in_last,
    input  aifs_pkg::cfg_t      cfg,
    input  logic                rec_load,    // record register may take a new value
    output logic                rec_valid,
    output aifs_pkg::field_rec_t rec
);

    logic                  phase_reg;
    logic                  phase_next;
    aifs_pkg::scan_state_t state_reg;
    aifs_pkg::scan_state_t state_next;
    aifs_pkg::scan_state_t eff;
    aifs_pkg::scan_state_t src;
    logic                  rec_valid_reg;
    aifs_pkg::field_rec_t  rec_reg;
    aifs_pkg::field_rec_t  rec_next;

    logic        blank;
    logic        skip_blank;
    logic        is_zero, is_dec, is_hexl, is_sign, is_x;
    logic        ok;
    logic        add;
    logic [3:0]  digit;
    logic [67:0] prod;
    logic [67:0] sum;
    logic [7:0]  limit;
    logic        emit;
    logic        rejected;

    // Classify the character
    always_comb begin
        blank   = (in_char == aifs_pkg::CH_SPACE) ||
                  (in_char >= aifs_pkg::CH_TAB && in_char <= aifs_pkg::CH_CR);
        is_zero = (in_char == aifs_pkg::CH_ZERO);
        is_dec  = (in_char >= aifs_pkg::CH_ONE && in_char <= aifs_pkg::CH_NINE);
        is_hexl = (in_char >= aifs_pkg::CH_LO_A && in_char <= aifs_pkg::CH_LO_F) ||
                  (in_char >= aifs_pkg::CH_UP_A && in_char <= aifs_pkg::CH_UP_F);
        is_sign = (in_char == aifs_pkg::CH_PLUS) || (in_char == aifs_pkg::CH_MINUS);
        is_x    = (in_char == aifs_pkg::CH_LO_X) || (in_char == aifs_pkg::CH_UP_X);
        digit   = is_hexl ? (4'(in_char[2:0]) + 4'd9) : in_char[3:0];
        limit   = (cfg.field_width == 5'd0 ||
                   {3'b000, cfg.field_width} > 8'(aifs_pkg::MAX_FIELD_CHARS)) ?
                  8'(aifs_pkg::MAX_FIELD_CHARS) : {3'b000, cfg.field_width};
    end

    // Next scan state
    always_comb begin
        // Between fields the state is a fresh one built from the live registers
        eff = state_reg;
        if (!phase_reg) begin
            eff.sign_ok         = 1'b1;
            eff.no_digits_yet   = 1'b1;
            eff.prefix_ok       = cfg.prefix_allowed;
            eff.no_nonzero_seen = 1'b1;
            eff.working_base    = aifs_pkg::legal_base(cfg.base_mode);
            eff.accepted_count  = 8'd0;
            eff.magnitude       = 64'd0;
            eff.is_negative     = 1'b0;
            eff.saturated       = 1'b0;
            eff.last_was_x      = 1'b0;
        end

        skip_blank = !phase_reg && blank;
        state_next = eff;
        ok         = 1'b0;
        add        = 1'b0;

        if (!skip_blank) begin
            if (is_zero) begin
                if (eff.working_base == aifs_pkg::BASE_AUTO) begin
                    state_next.working_base = aifs_pkg::BASE_OCT;
                    state_next.prefix_ok    = 1'b1;
                end
                if (eff.no_nonzero_seen) begin
                    state_next.no_nonzero_seen = 1'b0;
                end else begin
                    state_next.prefix_ok = 1'b0;
                end
                ok  = 1'b1;
                add = 1'b1;
            end else if (is_dec) begin
                if (eff.working_base == aifs_pkg::BASE_AUTO) begin
                    state_next.working_base = aifs_pkg::BASE_DEC;
                end
                if (in_char <= aifs_pkg::CH_SEVEN ||
                    state_next.working_base > aifs_pkg::BASE_OCT) begin
                    state_next.prefix_ok = 1'b0;
                    ok  = 1'b1;
                    add = 1'b1;
                end
            end else if (is_hexl) begin
                if (eff.working_base > aifs_pkg::BASE_DEC) begin
                    state_next.prefix_ok = 1'b0;
                    ok  = 1'b1;
                    add = 1'b1;
                end
            end else if (is_sign) begin
                if (eff.sign_ok) begin
                    state_next.is_negative = (in_char == aifs_pkg::CH_MINUS);
                    ok = 1'b1;
                end
            end else if (is_x) begin
                if (eff.prefix_ok && !eff.no_digits_yet) begin
                    state_next.working_base = aifs_pkg::BASE_HEX;
                    state_next.prefix_ok    = 1'b0;
                    ok = 1'b1;
                end
            end
        end

        // Multiply by the base with shifts and add the digit
        case (state_next.working_base)
            aifs_pkg::BASE_OCT: prod = {1'b0, eff.magnitude, 3'b000};
            aifs_pkg::BASE_HEX: prod = {eff.magnitude, 4'b0000};
            default:            prod = {1'b0, eff.magnitude, 3'b000} +
                                       {3'b000, eff.magnitude, 1'b0};
        endcase
        sum = prod + {64'd0, digit};

        if (ok) begin
            state_next.sign_ok    = 1'b0;
            state_next.last_was_x = is_x;
            if (eff.accepted_count != aifs_pkg::COUNT_MAX) begin
                state_next.accepted_count = eff.accepted_count + 8'd1;
            end
        end
        if (add) begin
            state_next.no_digits_yet = 1'b0;
            if (!eff.saturated) begin
                if (|sum[67:64]) begin
                    state_next.saturated = 1'b1;
                end else begin
                    state_next.magnitude = sum[63:0];
                end
            end
        end

        // Decide whether this character closes the field
        rejected = !skip_blank && !ok;
        if (skip_blank) begin
            emit = in_last;
        end else if (!ok) begin
            emit = 1'b1;
        end else begin
            emit = in_last ||
                   (!cfg.suppress_value && state_next.accepted_count >= limit);
        end
        phase_next = !skip_blank && !emit;

        // Build the finished-field record; a dangling x is given back
        src                  = ok ? state_next : eff;
        rec_next.magnitude   = src.magnitude;
        rec_next.is_negative = src.is_negative;
        rec_next.saturated   = src.saturated;
        rec_next.no_digits   = src.no_digits_yet;
        rec_next.chars_used  = src.accepted_count -
                               8'(src.last_was_x && src.accepted_count != 8'd0);
        rec_next.unused_tail = {1'b0, rejected} + {1'b0, src.last_was_x};
    end

    // Advance scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            state_reg <= state_next;
        end
    end

    // Hold the finished field until the formatter takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= 1'b0;
        end else if (rec_load) begin
            rec_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_load && step && emit) begin
            rec_reg <= rec_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

/* rtl/core/aifs_format.sv */
`timescale 1ns / 1ps
// Result formatting and output register: applies strtoll / strtoull
// saturation and sign to a finished field. Depends on aifs_pkg.
module aifs_format (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rec_valid,
    input  aifs_pkg::field_rec_t rec,
    input  aifs_pkg::cfg_t       cfg,
    input  logic                 m_tready,
    output logic                 out_free,
    output logic                 m_tvalid,
    output logic [79:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

    logic        m_valid_reg;
    logic [79:0] data_reg;
    logic [1:0]  user_reg;
    logic [63:0] value;
    logic        ovf;
    logic [63:0] neg_mag;
    logic        above_top;

    // Saturate and apply sign
    always_comb begin
        neg_mag   = 64'd0 - rec.magnitude;
        above_top = rec.magnitude[63] && (|rec.magnitude[62:0]);
        value     = 64'd0;
        ovf       = 1'b0;
        if (!rec.no_digits && !cfg.suppress_value) begin
            if (cfg.unsigned_mode) begin
                if (rec.saturated) begin
                    value = '1;
                    ovf   = 1'b1;
                end else begin
                    value = rec.is_negative ? neg_mag : rec.magnitude;
                end
            end else if (rec.is_negative) begin
                if (rec.saturated || above_top) begin
                    value = TOP_BIT;
                    ovf   = 1'b1;
                end else begin
                    value = neg_mag;
                end
            end else begin
                if (rec.saturated || rec.magnitude[63]) begin
                    value = TOP_BIT - 64'd1;
                    ovf   = 1'b1;
                end else begin
                    value = rec.magnitude;
                end
            end
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    // Output register: load when empty or when the receiver takes the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && rec_valid) begin
            data_reg <= {6'd0, rec.unused_tail, rec.chars_used, value};
            user_reg <= {ovf, rec.no_digits};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

/* rtl/core/aifs_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the ASCII integer field scanner, bound to the top
// level. Depends on the top level's port list only.
module aifs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A failed field reports zero and no overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[63:0] == 64'd0 && !m_tuser[1])
        else $error("failed field carries a value");

    // Overflow only ever reports a saturation value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[63:0] == 64'hFFFF_FFFF_FFFF_FFFF ||
            m_tdata[63:0] == 64'h8000_0000_0000_0000 ||
            m_tdata[63:0] == 64'h7FFF_FFFF_FFFF_FFFF)
        else $error("overflow with a non-saturated value");

    // A nonzero value consumed characters, and the tail never exceeds two
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[73:72] != 2'b11 &&
            (m_tdata[63:0] == 64'd0 || m_tdata[71:64] != 8'd0))
        else $error("inconsistent character accounting");

endmodule

bind ascii_integer_field_scanner aifs_checker u_aifs_checker (.*);
